// ----- rtl/bou_pkg.sv -----
package bou_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = 4;
  localparam int MAX_WORDS = 4;
  localparam int COUNT_W   = 3;

  typedef enum logic [3:0] {
    OP_ARSHIFT = 4'd0,
    OP_AND     = 4'd1,
    OP_NOT     = 4'd2,
    OP_OR      = 4'd3,
    OP_XOR     = 4'd4,
    OP_TEST    = 4'd5,
    OP_EXTRACT = 4'd6,
    OP_LROTATE = 4'd7,
    OP_LSHIFT  = 4'd8,
    OP_REPLACE = 4'd9,
    OP_RROTATE = 4'd10,
    OP_RSHIFT  = 4'd11,
    OP_CLZ     = 4'd12,
    OP_CTZ     = 4'd13
  } op_t;

  typedef struct packed {
    logic [3:0]                       op;
    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    logic [COUNT_W-1:0]               word_count;
    logic signed [WORD_W-1:0]         shift_amount;
    logic signed [WORD_W-1:0]         field_start;
    logic signed [WORD_W-1:0]         field_width;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic              is_boolean;
    logic              handled;
  } result_t;

endpackage

// ----- rtl/bou_alu.sv -----
module bou_alu
  import bou_pkg::*;
(
  input  item_t   item,
  output result_t res
);

  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [5:0]  n;
    logic [31:0] x;
    n = 6'd0;
    x = v;
    if (v == 32'd0) begin
      n = 6'd32;
    end else begin
      if (x[31:16] == 16'd0) begin n = n + 6'd16; x = x << 16; end
      if (x[31:24] == 8'd0)  begin n = n + 6'd8;  x = x << 8;  end
      if (x[31:28] == 4'd0)  begin n = n + 6'd4;  x = x << 4;  end
      if (x[31:30] == 2'd0)  begin n = n + 6'd2;  x = x << 2;  end
      if (x[31] == 1'b0)     begin n = n + 6'd1;               end
    end
    return n;
  endfunction

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  logic [31:0] w0;
  logic [31:0] w1;
  logic        shift_ok;
  logic [4:0]  amt;
  logic [4:0]  rot_amt;
  logic        count_ok;
  logic [31:0] acc_and;
  logic [31:0] acc_or;
  logic [31:0] acc_xor;
  logic        field_ok;
  logic [32:0] field_end;
  logic [4:0]  fstart;
  logic [31:0] fmask;
  logic [31:0] res_word;
  logic        res_bool;
  logic        res_ok;

  assign w0 = item.words[0];
  assign w1 = item.words[1];

  // shifts are handled only for 0..31
  assign shift_ok = (item.shift_amount[31:5] == 27'd0);
  assign amt      = item.shift_amount[4:0];
  assign rot_amt  = item.shift_amount[4:0];

  assign count_ok = (item.word_count != '0) && (int'(item.word_count) <= MAX_WORDS);

  always_comb begin
    acc_and = '1;
    acc_or  = '0;
    acc_xor = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (int'(item.word_count) > i) begin
        acc_and = acc_and & item.words[i];
        acc_or  = acc_or | item.words[i];
        acc_xor = acc_xor ^ item.words[i];
      end
    end
  end

  // start and width both nonnegative here, so the sum fits in 33 bits
  assign field_end = {1'b0, item.field_start} + {1'b0, item.field_width};
  assign field_ok  = !item.field_start[31] && !item.field_width[31]
                     && (item.field_width != '0) && (field_end <= 33'd32);
  assign fstart    = item.field_start[4:0];
  assign fmask     = ~(32'hfffffffe << (item.field_width[4:0] - 5'd1));

  always_comb begin
    res_word = '0;
    res_bool = 1'b0;
    res_ok   = 1'b1;
    unique case (op_t'(item.op))
      OP_ARSHIFT: begin
        res_ok   = shift_ok;
        res_word = 32'($signed(w0) >>> amt);
      end
      OP_AND: begin
        res_ok   = count_ok;
        res_word = acc_and;
      end
      OP_OR: begin
        res_ok   = count_ok;
        res_word = acc_or;
      end
      OP_XOR: begin
        res_ok   = count_ok;
        res_word = acc_xor;
      end
      OP_TEST: begin
        res_ok   = count_ok;
        res_word = {31'd0, (acc_and != '0)};
        res_bool = 1'b1;
      end
      OP_NOT: begin
        res_word = ~w0;
      end
      OP_EXTRACT: begin
        res_ok   = field_ok;
        res_word = (w0 >> fstart) & fmask;
      end
      OP_REPLACE: begin
        res_ok   = field_ok;
        res_word = (w0 & ~(fmask << fstart)) | ((w1 & fmask) << fstart);
      end
      OP_LROTATE: begin
        res_word = 32'({w0, w0} << rot_amt >> 32);
      end
      OP_RROTATE: begin
        res_word = 32'({w0, w0} >> rot_amt);
      end
      OP_LSHIFT: begin
        res_ok   = shift_ok;
        res_word = w0 << amt;
      end
      OP_RSHIFT: begin
        res_ok   = shift_ok;
        res_word = w0 >> amt;
      end
      OP_CLZ: begin
        res_word = {26'd0, clz32(w0)};
      end
      OP_CTZ: begin
        res_word = {26'd0, clz32(rev32(w0))};
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    if (!res_ok) begin
      res_word = '0;
      res_bool = 1'b0;
    end
  end

  assign res.result_word = res_word;
  assign res.is_boolean  = res_bool;
  assign res.handled     = res_ok;

endmodule

// ----- rtl/bit32_operation_unit_top.sv -----
// path: an accepted item is held in the input register, then its alu result in the result register
// throughput: one item per cycle, sustained as long as out_tready stays high
// all operations finish in one pass through the combinational alu between the registers
// reset: synchronous, active-low rst_n clears both valid flags; payload registers hold
// in_tready only drops while the result register is full and out_tready is low
module bit32_operation_unit_top
  import bou_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,

  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // word0[31:0], word1[63:32], word2[95:64], word3[127:96], word_count[130:128],
  // shift_amount[162:131], field_start[194:163], field_width[226:195], zero pad [231:227]
  input  logic [231:0] in_tdata,
  // op[3:0]
  input  logic [3:0]   in_tuser,

  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_word[31:0]
  output logic [31:0]  out_tdata,
  // is_boolean[0], handled[1]
  output logic [1:0]   out_tuser
);

  // input stage
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    s1_load;

  // result stage
  logic    s2_valid_r;
  result_t s2_res_r;
  logic    s2_load;

  result_t alu_res;

  // result register takes a new item when it is empty or being drained
  assign s2_load   = !s2_valid_r || out_tready;
  // input register moves forward whenever the result stage can take its item
  assign in_tready = !s1_valid_r || s2_load;
  assign s1_load   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // unpack the item fields into the stage register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r.op           <= in_tuser;
      s1_item_r.words[0]     <= in_tdata[31:0];
      s1_item_r.words[1]     <= in_tdata[63:32];
      s1_item_r.words[2]     <= in_tdata[95:64];
      s1_item_r.words[3]     <= in_tdata[127:96];
      s1_item_r.word_count   <= in_tdata[130:128];
      s1_item_r.shift_amount <= in_tdata[162:131];
      s1_item_r.field_start  <= in_tdata[194:163];
      s1_item_r.field_width  <= in_tdata[226:195];
    end
  end

  bou_alu u_alu (
    .item (s1_item_r),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_res_r <= alu_res;
    end
  end

  assign out_tvalid   = s2_valid_r;
  assign out_tdata    = s2_res_r.result_word;
  assign out_tuser[0] = s2_res_r.is_boolean;
  assign out_tuser[1] = s2_res_r.handled;

  // back-pressure only comes from a full, stalled result register
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s2_valid_r && !out_tready))
    else $error("input stalled without output back-pressure");

  // a boolean result is always a handled one
  a_bool_handled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tuser[1])
    else $error("is_boolean set on an unhandled item");

  // unhandled items carry a zero word
  a_unhandled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata == 32'd0))
    else $error("unhandled item with nonzero result word");

  // a test result is a single truth bit
  a_bool_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[31:1] == 31'd0))
    else $error("test result wider than one bit");

  // an item in the input stage reaches the result stage on the next edge when it can
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_load) |=> s2_valid_r)
    else $error("item lost between stages");

endmodule
